// ===== hdl/gtm_pkg.sv =====
`timescale 1ns / 1ps
package gtm_pkg;

    // Operand pair selected for the shared multiplier
    typedef enum logic [2:0] {
        MOP_PK = 3'd0,   // pair sum times momentum
        MOP_TK = 3'd1,   // momentum moment times momentum
        MOP_RX = 3'd2,   // row sum times position
        MOP_UX = 3'd3,   // position moment times position
        MOP_N1 = 3'd4,   // total times momentum step
        MOP_N2 = 3'd5,   // norm times position step
        MOP_N3 = 3'd6,   // norm times one over two pi
        MOP_MM = 3'd7    // mean squared
    } t_mop;

    // Right shift applied to a product
    typedef enum logic [2:0] {
        SH_0  = 3'd0,
        SH_16 = 3'd1,
        SH_24 = 3'd2,
        SH_26 = 3'd3,
        SH_32 = 3'd4
    } t_msh;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_NEGVAR = 2'd2;

    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic capture;
        logic mul_go;
        t_mop mul_op;
        logic row_acc1;
        logic row_acc2;
        logic col_end;
        logic u_ld;
        logic u2_ld;
        logic tot_add;
        logic row_end;
        logic norm_ld;
        logic axis_clr;
        logic axis_next;
        logic div_go;
        logic div_e2;
        logic mean_ld;
        logic e2_ld;
        logic var_ld;
        logic sqrt_go;
        logic spread_ld;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic col_first;
        logic col_last;
        logic row_last;
        logic weight2;
        logic mul_done;
        logic dsq_done;
        logic total_zero;
        logic var_neg;
        logic axis;
        logic per_two_pi;
        logic out_busy;
    } t_sts;

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] from_mag64(input logic [63:0] m, input logic neg);
        logic signed [63:0] r;
        if (neg) begin
            r = m[63] ? S64_MIN : -$signed(m);
        end else begin
            r = m[63] ? S64_MAX : $signed(m);
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a + b;
        if (!a[63] && !b[63] && r[63]) begin
            r = S64_MAX;
        end else if (a[63] && b[63] && !r[63]) begin
            r = S64_MIN;
        end
        return r;
    endfunction

endpackage

// ===== hdl/gtm_mul.sv =====
`timescale 1ns / 1ps
module gtm_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic signed [63:0]  i_a,
    input  logic signed [32:0]  i_b,
    input  gtm_pkg::t_msh       i_sh,
    output logic                o_done,
    output logic signed [63:0]  o_res
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_LO   = 4'b0010,
        M_HI   = 4'b0100,
        M_FIN  = 4'b1000
    } t_mst;

    t_mst                r_st, n_st;
    logic [63:0]         r_am;
    logic [31:0]         r_bm;
    logic                r_neg;
    gtm_pkg::t_msh       r_sh;
    logic [95:0]         r_acc;
    logic                r_done;
    logic signed [63:0]  r_res;
    logic [32:0]         b_abs;
    logic [95:0]         shifted;
    logic [63:0]         sat_mag;

    // Magnitude of the short operand
    assign b_abs = i_b[32] ? 33'(-i_b) : 33'(i_b);

    // Scale and saturate the magnitude of the product
    always_comb begin
        case (r_sh)
            gtm_pkg::SH_0:  shifted = r_acc;
            gtm_pkg::SH_16: shifted = r_acc >> 16;
            gtm_pkg::SH_24: shifted = r_acc >> 24;
            gtm_pkg::SH_26: shifted = r_acc >> 26;
            default:        shifted = r_acc >> 32;
        endcase
        sat_mag = (|shifted[95:64]) ? '1 : shifted[63:0];
    end

    // Step through low and high partial products
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            M_IDLE:  if (i_go) n_st = M_LO;
            M_LO:    n_st = M_HI;
            M_HI:    n_st = M_FIN;
            M_FIN:   n_st = M_IDLE;
            default: n_st = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= M_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == M_FIN);
        end
    end

    // Datapath of the multiplier
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            M_IDLE: begin
                if (i_go) begin
                    r_am  <= gtm_pkg::mag64(i_a);
                    r_bm  <= b_abs[31:0];
                    r_neg <= i_a[63] ^ i_b[32];
                    r_sh  <= i_sh;
                end
            end
            M_LO:  r_acc <= {32'b0, 64'(r_am[31:0]) * 64'(r_bm)};
            M_HI:  r_acc <= r_acc + {64'(r_am[63:32]) * 64'(r_bm), 32'b0};
            M_FIN: r_res <= gtm_pkg::from_mag64(sat_mag, r_neg);
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hdl/gtm_dsq.sv =====
`timescale 1ns / 1ps
module gtm_dsq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go_div,
    input  logic                i_go_sqrt,
    input  logic signed [63:0]  i_num,
    input  logic signed [63:0]  i_den,
    input  logic                i_sh32,
    input  logic [63:0]         i_rad,
    output logic                o_done,
    output logic signed [63:0]  o_res
);

    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'd31;

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_CHK  = 5'b00010,
        D_DIV  = 5'b00100,
        D_SQRT = 5'b01000,
        D_FIN  = 5'b10000
    } t_dst;

    t_dst                r_st, n_st;
    logic [63:0]         r_rem;
    logic [63:0]         r_lo;
    logic [63:0]         r_q;
    logic [63:0]         r_ud;
    logic                r_neg;
    logic [5:0]          r_cnt;
    logic                r_done;
    logic signed [63:0]  r_res;
    logic [63:0]         un;
    logic [63:0]         rs;
    logic                take;
    logic [63:0]         sq_sum;

    // Restoring divide step and root step
    always_comb begin
        un     = gtm_pkg::mag64(i_num);
        rs     = {r_rem[62:0], r_lo[63]};
        take   = r_rem[63] || (rs >= r_ud);
        sq_sum = r_q + r_lo;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            D_IDLE: begin
                if (i_go_div) begin
                    n_st = D_CHK;
                end else if (i_go_sqrt) begin
                    n_st = D_SQRT;
                end
            end
            D_CHK:   n_st = (r_rem >= r_ud) ? D_FIN : D_DIV;
            D_DIV:   if (r_cnt == DIV_LAST) n_st = D_FIN;
            D_SQRT:  if (r_cnt == SQRT_LAST) n_st = D_FIN;
            D_FIN:   n_st = D_IDLE;
            default: n_st = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == D_FIN);
        end
    end

    // One quotient bit or one root bit per cycle
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            D_IDLE: begin
                r_cnt <= '0;
                r_q   <= '0;
                if (i_go_div) begin
                    r_ud  <= gtm_pkg::mag64(i_den);
                    r_neg <= i_num[63] ^ i_den[63];
                    r_lo  <= i_sh32 ? (un << 32) : (un << 16);
                    r_rem <= i_sh32 ? (un >> 32) : (un >> 48);
                end else if (i_go_sqrt) begin
                    r_neg <= 1'b0;
                    r_rem <= i_rad;
                    r_lo  <= 64'h4000_0000_0000_0000;
                end
            end
            D_CHK: begin
                if (r_rem >= r_ud) r_q <= '1;
            end
            D_DIV: begin
                r_lo  <= r_lo << 1;
                r_cnt <= r_cnt + 6'd1;
                if (take) begin
                    r_rem <= rs - r_ud;
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= rs;
                    r_q   <= {r_q[62:0], 1'b0};
                end
            end
            D_SQRT: begin
                r_lo  <= r_lo >> 2;
                r_cnt <= r_cnt + 6'd1;
                if (r_rem >= sq_sum) begin
                    r_rem <= r_rem - sq_sum;
                    r_q   <= (r_q >> 1) + r_lo;
                end else begin
                    r_q <= r_q >> 1;
                end
            end
            D_FIN:   r_res <= gtm_pkg::from_mag64(r_q, r_neg);
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hdl/gtm_dp.sv =====
`timescale 1ns / 1ps
module gtm_dp #(
    parameter int MAX_ROWS = 4096,
    parameter int MAX_COLS = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    input  logic [95:0]     i_s_tdata,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [175:0]    o_m_tdata,
    output logic [1:0]      o_m_tuser,
    input  gtm_pkg::t_cmd   i_cmd,
    output gtm_pkg::t_sts   o_sts
);

    localparam int RIW = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RXW = RCW + 1;
    localparam int CXW = CCW + 1;

    localparam logic [2:0] REG_ROWS = 3'd0;
    localparam logic [2:0] REG_COLS = 3'd1;
    localparam logic [2:0] REG_MOM  = 3'd2;
    localparam logic [2:0] REG_POS  = 3'd3;
    localparam logic [2:0] REG_PER  = 3'd4;

    localparam logic signed [63:0] M32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] M32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] N48_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] N48_MIN = -64'sd140737488355328;
    localparam logic signed [63:0] SD_MAX  = 64'sd2147483647;

    // Configuration
    logic [12:0]         r_grid_rows, r_grid_cols;
    logic [31:0]         r_mom_step, r_pos_step;
    logic                r_per;
    // Current item
    logic signed [31:0]  r_s, r_x, r_k, r_prev;
    logic signed [32:0]  r_p;
    // Grid state
    logic [RIW-1:0]      r_row;
    logic [CIW-1:0]      r_col;
    logic signed [63:0]  r_row_sum, r_rmom, r_rmsq;
    logic signed [63:0]  r_tot, r_tpos, r_tpsq, r_tmom, r_tmsq;
    logic signed [63:0]  r_t, r_u, r_u2, r_norm, r_e2, r_var;
    logic                r_axis, r_neg;
    logic signed [31:0]  r_mean_p, r_mean_m;
    logic [30:0]         r_sd_p, r_sd_m;
    // Result register
    logic                r_ovalid;
    logic [47:0]         r_o_norm;
    logic [31:0]         r_o_mean_p, r_o_mean_m;
    logic [30:0]         r_o_sd_p, r_o_sd_m;
    logic [1:0]          r_o_status;

    logic [RCW-1:0]      rows_c;
    logic [CCW-1:0]      cols_c;
    logic                row_last, col_last;
    logic signed [63:0]  mul_a;
    logic signed [32:0]  mul_b;
    gtm_pkg::t_msh       mul_sh;
    logic                mul_done, dsq_done;
    logic signed [63:0]  mres, dres;
    logic signed [31:0]  mean_cur, mean_clamped;
    logic [30:0]         sd_clamped;
    logic signed [63:0]  p_ext, norm_clamped;

    // Clamp the grid counts
    always_comb begin
        if (r_grid_rows < 13'd2) rows_c = RCW'(2);
        else if (32'(r_grid_rows) > 32'(MAX_ROWS)) rows_c = RCW'(MAX_ROWS);
        else rows_c = RCW'(r_grid_rows);
        if (r_grid_cols < 13'd2) cols_c = CCW'(2);
        else if (32'(r_grid_cols) > 32'(MAX_COLS)) cols_c = CCW'(MAX_COLS);
        else cols_c = CCW'(r_grid_cols);
        row_last = (RXW'(r_row) + RXW'(1)) >= RXW'(rows_c);
        col_last = (CXW'(r_col) + CXW'(1)) >= CXW'(cols_c);
    end

    assign p_ext    = {{31{r_p[32]}}, r_p};
    assign mean_cur = r_axis ? r_mean_m : r_mean_p;

    // Select multiplier operands
    always_comb begin
        mul_a  = r_t;
        mul_b  = {r_k[31], r_k};
        mul_sh = gtm_pkg::SH_16;
        case (i_cmd.mul_op)
            gtm_pkg::MOP_PK: mul_a = p_ext;
            gtm_pkg::MOP_TK: mul_a = r_t;
            gtm_pkg::MOP_RX: begin
                mul_a = r_row_sum;
                mul_b = {r_x[31], r_x};
            end
            gtm_pkg::MOP_UX: begin
                mul_a = r_u;
                mul_b = {r_x[31], r_x};
            end
            gtm_pkg::MOP_N1: begin
                mul_a  = r_tot;
                mul_b  = {1'b0, r_mom_step};
                mul_sh = gtm_pkg::SH_24;
            end
            gtm_pkg::MOP_N2: begin
                mul_a  = r_norm;
                mul_b  = {1'b0, r_pos_step};
                mul_sh = gtm_pkg::SH_26;
            end
            gtm_pkg::MOP_N3: begin
                mul_a  = r_norm;
                mul_b  = {1'b0, gtm_pkg::INV_TWO_PI_Q32};
                mul_sh = gtm_pkg::SH_32;
            end
            default: begin
                mul_a  = {{32{mean_cur[31]}}, mean_cur};
                mul_b  = {mean_cur[31], mean_cur};
                mul_sh = gtm_pkg::SH_0;
            end
        endcase
    end

    gtm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_sh    (mul_sh),
        .o_done  (mul_done),
        .o_res   (mres)
    );

    gtm_dsq u_dsq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go_div  (i_cmd.div_go),
        .i_go_sqrt (i_cmd.sqrt_go),
        .i_num     (i_cmd.div_e2 ? (r_axis ? r_tmsq : r_tpsq) : (r_axis ? r_tmom : r_tpos)),
        .i_den     (r_tot),
        .i_sh32    (i_cmd.div_e2),
        .i_rad     (64'(r_var)),
        .o_done    (dsq_done),
        .o_res     (dres)
    );

    // Clamp the quotient, root and norm
    always_comb begin
        if (dres > M32_MAX) mean_clamped = 32'sh7FFF_FFFF;
        else if (dres < M32_MIN) mean_clamped = 32'sh8000_0000;
        else mean_clamped = dres[31:0];
        sd_clamped = (dres > SD_MAX) ? 31'h7FFF_FFFF : dres[30:0];
        if (r_norm > N48_MAX) norm_clamped = N48_MAX;
        else if (r_norm < N48_MIN) norm_clamped = N48_MIN;
        else norm_clamped = r_norm;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= 13'd256;
            r_grid_cols <= 13'd256;
            r_mom_step  <= 32'd16777216;
            r_pos_step  <= 32'd16777216;
            r_per       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROWS: r_grid_rows <= i_cfg_data[12:0];
                REG_COLS: r_grid_cols <= i_cfg_data[12:0];
                REG_MOM:  r_mom_step  <= i_cfg_data;
                REG_POS:  r_pos_step  <= i_cfg_data;
                REG_PER:  r_per       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Hold the current item and its pair sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_s <= i_s_tdata[31:0];
            r_x <= i_s_tdata[63:32];
            r_k <= i_s_tdata[95:64];
            r_p <= 33'(signed'(i_s_tdata[31:0])) + 33'(r_prev);
        end
    end

    // Row and grid accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_prev    <= '0;
            r_row_sum <= '0;
            r_rmom    <= '0;
            r_rmsq    <= '0;
            r_tot     <= '0;
            r_tpos    <= '0;
            r_tpsq    <= '0;
            r_tmom    <= '0;
            r_tmsq    <= '0;
        end else begin
            if (i_cmd.row_acc1) begin
                r_row_sum <= gtm_pkg::sat_add64(r_row_sum, p_ext);
                r_rmom    <= gtm_pkg::sat_add64(r_rmom, mres);
            end
            if (i_cmd.row_acc2) r_rmsq <= gtm_pkg::sat_add64(r_rmsq, mres);
            if (i_cmd.col_end) begin
                if (col_last) begin
                    r_col  <= '0;
                    r_prev <= '0;
                end else begin
                    r_col  <= r_col + CIW'(1);
                    r_prev <= r_s;
                end
            end
            if (i_cmd.tot_add) begin
                r_tot  <= gtm_pkg::sat_add64(r_tot, r_row_sum);
                r_tpos <= gtm_pkg::sat_add64(r_tpos, r_u);
                r_tpsq <= gtm_pkg::sat_add64(r_tpsq, r_u2);
                r_tmom <= gtm_pkg::sat_add64(r_tmom, r_rmom);
                r_tmsq <= gtm_pkg::sat_add64(r_tmsq, r_rmsq);
            end
            if (i_cmd.row_end) begin
                r_row_sum <= '0;
                r_rmom    <= '0;
                r_rmsq    <= '0;
                if (!row_last) r_row <= r_row + RIW'(1);
            end
            if (i_cmd.emit) begin
                r_row  <= '0;
                r_col  <= '0;
                r_prev <= '0;
                r_tot  <= '0;
                r_tpos <= '0;
                r_tpsq <= '0;
                r_tmom <= '0;
                r_tmsq <= '0;
            end
        end
    end

    // Intermediate products and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= 1'b0;
            r_neg  <= 1'b0;
        end else begin
            if (i_cmd.axis_clr) begin
                r_axis <= 1'b0;
                r_neg  <= 1'b0;
            end
            if (i_cmd.axis_next) r_axis <= 1'b1;
            if (i_cmd.spread_ld && r_var[63]) r_neg <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_acc1) r_t <= mres;
        if (i_cmd.u_ld) r_u <= mres;
        if (i_cmd.u2_ld) r_u2 <= mres;
        if (i_cmd.norm_ld) r_norm <= mres;
        if (i_cmd.mean_ld) begin
            if (r_axis) r_mean_m <= mean_clamped;
            else r_mean_p <= mean_clamped;
        end
        if (i_cmd.e2_ld) r_e2 <= dres;
        if (i_cmd.var_ld) r_var <= gtm_pkg::sat_add64(r_e2, -mres);
        if (i_cmd.spread_ld) begin
            if (r_axis) r_sd_m <= r_var[63] ? '0 : sd_clamped;
            else r_sd_p <= r_var[63] ? '0 : sd_clamped;
        end
    end

    // Result register: load on emit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_norm <= norm_clamped[47:0];
            if (r_tot == '0) begin
                r_o_mean_p <= '0;
                r_o_mean_m <= '0;
                r_o_sd_p   <= '0;
                r_o_sd_m   <= '0;
                r_o_status <= gtm_pkg::ST_ZERO;
            end else begin
                r_o_mean_p <= r_mean_p;
                r_o_mean_m <= r_mean_m;
                r_o_sd_p   <= r_sd_p;
                r_o_sd_m   <= r_sd_m;
                r_o_status <= r_neg ? gtm_pkg::ST_NEGVAR : gtm_pkg::ST_OK;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {2'b0, r_o_sd_m, r_o_mean_m, r_o_sd_p, r_o_mean_p, r_o_norm};
    assign o_m_tuser   = r_o_status;

    always_comb begin
        o_sts.col_first  = (r_col == '0);
        o_sts.col_last   = col_last;
        o_sts.row_last   = row_last;
        o_sts.weight2    = (r_row != '0) && !row_last;
        o_sts.mul_done   = mul_done;
        o_sts.dsq_done   = dsq_done;
        o_sts.total_zero = (r_tot == '0);
        o_sts.var_neg    = r_var[63];
        o_sts.axis       = r_axis;
        o_sts.per_two_pi = r_per;
        o_sts.out_busy   = r_ovalid && !i_m_tready;
    end

`ifndef NO_ASSERTIONS
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_tot == '0 && r_row == '0 && r_col == '0))
        else $error("grid state not cleared after result");
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == gtm_pkg::ST_ZERO) |-> (o_m_tdata[173:48] == '0))
        else $error("zero norm result carries statistics");
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(i_cmd.emit))
        else $error("result raised without emit");
`endif

endmodule

// ===== hdl/gtm_ctrl.sv =====
`timescale 1ns / 1ps
module gtm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  gtm_pkg::t_sts   i_sts,
    output gtm_pkg::t_cmd   o_cmd
);

    typedef enum logic [26:0] {
        S_IDLE = 27'd1 << 0,
        S_COL  = 27'd1 << 1,
        S_WPK  = 27'd1 << 2,
        S_TK   = 27'd1 << 3,
        S_WTK  = 27'd1 << 4,
        S_CEND = 27'd1 << 5,
        S_WRX  = 27'd1 << 6,
        S_UX   = 27'd1 << 7,
        S_WUX  = 27'd1 << 8,
        S_TOT1 = 27'd1 << 9,
        S_TOT2 = 27'd1 << 10,
        S_REND = 27'd1 << 11,
        S_WN1  = 27'd1 << 12,
        S_N2   = 27'd1 << 13,
        S_WN2  = 27'd1 << 14,
        S_N3   = 27'd1 << 15,
        S_WN3  = 27'd1 << 16,
        S_ZCHK = 27'd1 << 17,
        S_DM   = 27'd1 << 18,
        S_WDM  = 27'd1 << 19,
        S_DE   = 27'd1 << 20,
        S_WDE  = 27'd1 << 21,
        S_MM   = 27'd1 << 22,
        S_WMM  = 27'd1 << 23,
        S_SQ   = 27'd1 << 24,
        S_WSQ  = 27'd1 << 25,
        S_EMIT = 27'd1 << 26
    } t_st;

    t_st r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Sequence one item, a row close and a grid close
    always_comb begin
        n_st  = r_st;
        o_cmd = '0;
        unique case (r_st)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_st = S_COL;
                end
            end
            S_COL: begin
                if (i_sts.col_first) begin
                    n_st = S_CEND;
                end else begin
                    o_cmd.mul_go = 1'b1;
                    o_cmd.mul_op = gtm_pkg::MOP_PK;
                    n_st = S_WPK;
                end
            end
            S_WPK: begin
                if (i_sts.mul_done) begin
                    o_cmd.row_acc1 = 1'b1;
                    n_st = S_TK;
                end
            end
            S_TK: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = gtm_pkg::MOP_TK;
                n_st = S_WTK;
            end
            S_WTK: begin
                if (i_sts.mul_done) begin
                    o_cmd.row_acc2 = 1'b1;
                    n_st = S_CEND;
                end
            end
            S_CEND: begin
                o_cmd.col_end = 1'b1;
                if (i_sts.col_last) begin
                    o_cmd.mul_go = 1'b1;
                    o_cmd.mul_op = gtm_pkg::MOP_RX;
                    n_st = S_WRX;
                end else begin
                    n_st = S_IDLE;
                end
            end
            S_WRX: begin
                if (i_sts.mul_done) begin
                    o_cmd.u_ld = 1'b1;
                    n_st = S_UX;
                end
            end
            S_UX: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = gtm_pkg::MOP_UX;
                n_st = S_WUX;
            end
            S_WUX: begin
                if (i_sts.mul_done) begin
                    o_cmd.u2_ld = 1'b1;
                    n_st = S_TOT1;
                end
            end
            S_TOT1: begin
                o_cmd.tot_add = 1'b1;
                n_st = i_sts.weight2 ? S_TOT2 : S_REND;
            end
            S_TOT2: begin
                o_cmd.tot_add = 1'b1;
                n_st = S_REND;
            end
            S_REND: begin
                o_cmd.row_end = 1'b1;
                if (i_sts.row_last) begin
                    o_cmd.mul_go = 1'b1;
                    o_cmd.mul_op = gtm_pkg::MOP_N1;
                    n_st = S_WN1;
                end else begin
                    n_st = S_IDLE;
                end
            end
            S_WN1: begin
                if (i_sts.mul_done) begin
                    o_cmd.norm_ld = 1'b1;
                    n_st = S_N2;
                end
            end
            S_N2: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = gtm_pkg::MOP_N2;
                n_st = S_WN2;
            end
            S_WN2: begin
                if (i_sts.mul_done) begin
                    o_cmd.norm_ld = 1'b1;
                    n_st = i_sts.per_two_pi ? S_N3 : S_ZCHK;
                end
            end
            S_N3: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = gtm_pkg::MOP_N3;
                n_st = S_WN3;
            end
            S_WN3: begin
                if (i_sts.mul_done) begin
                    o_cmd.norm_ld = 1'b1;
                    n_st = S_ZCHK;
                end
            end
            S_ZCHK: begin
                o_cmd.axis_clr = 1'b1;
                n_st = i_sts.total_zero ? S_EMIT : S_DM;
            end
            S_DM: begin
                o_cmd.div_go = 1'b1;
                n_st = S_WDM;
            end
            S_WDM: begin
                if (i_sts.dsq_done) begin
                    o_cmd.mean_ld = 1'b1;
                    n_st = S_DE;
                end
            end
            S_DE: begin
                o_cmd.div_go = 1'b1;
                o_cmd.div_e2 = 1'b1;
                n_st = S_WDE;
            end
            S_WDE: begin
                if (i_sts.dsq_done) begin
                    o_cmd.e2_ld = 1'b1;
                    n_st = S_MM;
                end
            end
            S_MM: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.mul_op = gtm_pkg::MOP_MM;
                n_st = S_WMM;
            end
            S_WMM: begin
                if (i_sts.mul_done) begin
                    o_cmd.var_ld = 1'b1;
                    n_st = S_SQ;
                end
            end
            S_SQ: begin
                if (i_sts.var_neg) begin
                    o_cmd.spread_ld = 1'b1;
                    if (i_sts.axis) begin
                        n_st = S_EMIT;
                    end else begin
                        o_cmd.axis_next = 1'b1;
                        n_st = S_DM;
                    end
                end else begin
                    o_cmd.sqrt_go = 1'b1;
                    n_st = S_WSQ;
                end
            end
            S_WSQ: begin
                if (i_sts.dsq_done) begin
                    o_cmd.spread_ld = 1'b1;
                    if (i_sts.axis) begin
                        n_st = S_EMIT;
                    end else begin
                        o_cmd.axis_next = 1'b1;
                        n_st = S_DM;
                    end
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_s_tready = (r_st == S_IDLE);

endmodule

// ===== hdl/grid_trapezoid_moments.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals                                  Contents
// s_axis    in         i_s_tvalid o_s_tready i_s_tdata[95:0]    sample, row_pos, col_mom
// m_axis    out        o_m_tvalid i_m_tready o_m_tdata[175:0]   moments of one grid
//                      o_m_tuser[1:0]                           status
// cfg       in         i_cfg_valid o_cfg_ready i_cfg_index      register write
//                      i_cfg_data[31:0]
//
// One sample at a time: the first column of a row takes no product; later columns take
// two products on the shared 64x32 multiplier, two 32x32 partial products each.
// A row close adds two more products and one total update, two for an inner row.
// A grid close runs the norm products, then the bit-serial divide and root unit
// (two quotients and one root per axis, no root on a negative variance).
// Synchronous active-low reset clears counters and accumulators; config regs take defaults.
// A pending result waits in the output register; the next grid runs behind it.
module grid_trapezoid_moments #(
    parameter int MAX_ROWS = 4096,
    parameter int MAX_COLS = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [95:0]     i_s_tdata,   // sample[31:0], row_pos[63:32], col_mom[95:64]
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [175:0]    o_m_tdata,   // norm[47:0], mean_pos[79:48], spread_pos[110:80],
                                         // mean_mom[142:111], spread_mom[173:143], zero pad
    output logic [1:0]      o_m_tuser,   // status[1:0]
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);

    gtm_pkg::t_cmd cmd;
    gtm_pkg::t_sts sts;

    gtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gtm_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== tb/grid_trapezoid_moments_checker.sv =====
`timescale 1ns / 1ps
module grid_trapezoid_moments_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_s_tready,
    input  logic [95:0]     i_s_tdata,   // sample[31:0], row_pos[63:32], col_mom[95:64]
    input  logic            i_m_tvalid,
    input  logic            i_m_tready,
    input  logic [175:0]    i_m_tdata,   // norm, mean_pos, spread_pos, mean_mom, spread_mom
    input  logic [1:0]      i_m_tuser,   // status[1:0]
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    output int              o_errors,
    output int              o_pending
);

    localparam int ROW_LIMIT = 4096;
    localparam int COL_LIMIT = 4096;
    localparam logic [2:0] REG_ROWS     = 3'd0;
    localparam logic [2:0] REG_COLS     = 3'd1;
    localparam logic [2:0] REG_MOM_STEP = 3'd2;
    localparam logic [2:0] REG_POS_STEP = 3'd3;
    localparam logic [2:0] REG_TWO_PI   = 3'd4;
    localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] NORM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] NORM_MIN = -64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [47:0] norm;
        logic [31:0] mean_pos;
        logic [30:0] spread_pos;
        logic [31:0] mean_mom;
        logic [30:0] spread_mom;
        logic [1:0]  status;
    } t_moments;

    t_moments moments_q[$];

    // Configuration copy
    logic [12:0] rows_reg, cols_reg;
    logic [31:0] mom_step_reg, pos_step_reg;
    logic        two_pi_reg;

    // Accumulator copy
    int unsigned row_idx, col_idx;
    logic signed [63:0] prev_smp, row_acc, row_k_acc, row_kk_acc;
    logic signed [63:0] tot_acc, tot_x_acc, tot_xx_acc, tot_k_acc, tot_kk_acc;

    assign o_pending = moments_q.size();

    function automatic logic [63:0] magnitude(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] signed_of(input logic [63:0] m, input bit neg);
        if (neg) return m[63] ? MIN64 : -$signed(m);
        return m[63] ? MAX64 : $signed(m);
    endfunction

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a + b;
        if (!a[63] && !b[63] && r[63]) r = MAX64;
        else if (a[63] && b[63] && !r[63]) r = MIN64;
        return r;
    endfunction

    // trunc(a*b / 2^sh), saturated
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                          input logic signed [63:0] b,
                                                          input int sh);
        logic [127:0] p;
        logic [63:0] lo;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = p >> sh;
        lo = (p[127:64] != 0) ? '1 : p[63:0];
        return signed_of(lo, a[63] != b[63]);
    endfunction

    // trunc(num*2^sh / den), saturated
    function automatic logic signed [63:0] scaled_quotient(input logic signed [63:0] num,
                                                           input logic signed [63:0] den,
                                                           input int sh);
        logic [127:0] n;
        logic [127:0] q;
        logic [63:0] ud;
        n = {64'd0, magnitude(num)} << sh;
        ud = magnitude(den);
        if (n[127:64] >= ud) q = '1;
        else q = n / {64'd0, ud};
        return signed_of(q[63:0], num[63] != den[63]);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Mean and spread of one axis; returns 1 on a negative variance
    function automatic bit axis_moments(input logic signed [63:0] s1, s2, s0,
                                        output logic [31:0] mean, output logic [30:0] spread);
        logic signed [63:0] m, e2, var_q32;
        logic [63:0] sd;
        m = scaled_quotient(s1, s0, 16);
        if (m > 64'sd2147483647) m = 64'sd2147483647;
        if (m < -64'sd2147483648) m = -64'sd2147483648;
        e2 = scaled_quotient(s2, s0, 32);
        var_q32 = sat_sum(e2, -(m * m));
        mean = m[31:0];
        if (var_q32 < 0) begin
            spread = 0;
            return 1;
        end
        sd = root_floor(var_q32);
        spread = (sd > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sd[30:0];
        return 0;
    endfunction

    function automatic int clamp_count(input logic [12:0] v, input int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic clear_grid();
        row_idx = 0;
        col_idx = 0;
        prev_smp = 0;
        row_acc = 0;
        row_k_acc = 0;
        row_kk_acc = 0;
        tot_acc = 0;
        tot_x_acc = 0;
        tot_xx_acc = 0;
        tot_k_acc = 0;
        tot_kk_acc = 0;
    endtask

    // Fold one grid sample into the running moments; queue a result at grid end
    task automatic absorb_sample(input logic signed [31:0] smp, input logic signed [31:0] x,
                                 input logic signed [31:0] k);
        logic signed [63:0] s64, x64, k64, p, t, u, u2, nrm;
        int rows, cols, w;
        bit neg_p, neg_k;
        t_moments res;
        rows = clamp_count(rows_reg, ROW_LIMIT);
        cols = clamp_count(cols_reg, COL_LIMIT);
        s64 = smp;
        x64 = x;
        k64 = k;
        if (col_idx > 0) begin
            p = s64 + prev_smp;
            t = scaled_product(p, k64, 16);
            row_acc = sat_sum(row_acc, p);
            row_k_acc = sat_sum(row_k_acc, t);
            row_kk_acc = sat_sum(row_kk_acc, scaled_product(t, k64, 16));
        end
        prev_smp = s64;
        if (col_idx + 1 < cols) begin
            col_idx++;
            return;
        end
        // Close the row; edge rows count half
        w = (row_idx == 0 || row_idx + 1 >= rows) ? 1 : 2;
        u = scaled_product(row_acc, x64, 16);
        u2 = scaled_product(u, x64, 16);
        repeat (w) begin
            tot_acc = sat_sum(tot_acc, row_acc);
            tot_x_acc = sat_sum(tot_x_acc, u);
            tot_xx_acc = sat_sum(tot_xx_acc, u2);
            tot_k_acc = sat_sum(tot_k_acc, row_k_acc);
            tot_kk_acc = sat_sum(tot_kk_acc, row_kk_acc);
        end
        row_acc = 0;
        row_k_acc = 0;
        row_kk_acc = 0;
        col_idx = 0;
        prev_smp = 0;
        if (row_idx + 1 < rows) begin
            row_idx++;
            return;
        end
        // Close the grid
        nrm = scaled_product(scaled_product(tot_acc, {32'd0, mom_step_reg}, 24),
                             {32'd0, pos_step_reg}, 26);
        if (two_pi_reg) nrm = scaled_product(nrm, {32'd0, gtm_pkg::INV_TWO_PI_Q32}, 32);
        if (nrm > NORM_MAX) nrm = NORM_MAX;
        if (nrm < NORM_MIN) nrm = NORM_MIN;
        res = '0;
        res.norm = nrm[47:0];
        if (tot_acc == 0) begin
            res.status = gtm_pkg::ST_ZERO;
        end else begin
            neg_p = axis_moments(tot_x_acc, tot_xx_acc, tot_acc, res.mean_pos, res.spread_pos);
            neg_k = axis_moments(tot_k_acc, tot_kk_acc, tot_acc, res.mean_mom, res.spread_mom);
            res.status = (neg_p || neg_k) ? gtm_pkg::ST_NEGVAR : gtm_pkg::ST_OK;
        end
        moments_q.push_back(res);
        clear_grid();
    endtask

    task automatic report(input string field, input logic [63:0] exp_v, input logic [63:0] act_v);
        o_errors++;
        if (o_errors <= 10)
            $display("mismatch %s: expected %h, got %h", field, exp_v, act_v);
    endtask

    // Watch every transfer
    always @(posedge i_clk) begin
        t_moments exp_m, act_m;
        if (!i_rst_n) begin
            rows_reg = 13'd256;
            cols_reg = 13'd256;
            mom_step_reg = 32'd16777216;
            pos_step_reg = 32'd16777216;
            two_pi_reg = 1'b0;
            o_errors = 0;
            clear_grid();
            moments_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROWS:     rows_reg = i_cfg_data[12:0];
                    REG_COLS:     cols_reg = i_cfg_data[12:0];
                    REG_MOM_STEP: mom_step_reg = i_cfg_data;
                    REG_POS_STEP: pos_step_reg = i_cfg_data;
                    REG_TWO_PI:   two_pi_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                absorb_sample(i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[95:64]);
            if (i_m_tvalid && i_m_tready) begin
                act_m.norm = i_m_tdata[47:0];
                act_m.mean_pos = i_m_tdata[79:48];
                act_m.spread_pos = i_m_tdata[110:80];
                act_m.mean_mom = i_m_tdata[142:111];
                act_m.spread_mom = i_m_tdata[173:143];
                act_m.status = i_m_tuser;
                if (moments_q.size() == 0) begin
                    report("unexpected result", 0, act_m.norm);
                end else begin
                    exp_m = moments_q.pop_front();
                    if (exp_m.norm != act_m.norm) report("norm", exp_m.norm, act_m.norm);
                    if (exp_m.mean_pos != act_m.mean_pos)
                        report("mean_pos", exp_m.mean_pos, act_m.mean_pos);
                    if (exp_m.spread_pos != act_m.spread_pos)
                        report("spread_pos", exp_m.spread_pos, act_m.spread_pos);
                    if (exp_m.mean_mom != act_m.mean_mom)
                        report("mean_mom", exp_m.mean_mom, act_m.mean_mom);
                    if (exp_m.spread_mom != act_m.spread_mom)
                        report("spread_mom", exp_m.spread_mom, act_m.spread_mom);
                    if (exp_m.status != act_m.status)
                        report("status", exp_m.status, act_m.status);
                end
            end
        end
    end
endmodule

// ===== tb/grid_trapezoid_moments_tb.sv =====
`timescale 1ns / 1ps
module grid_trapezoid_moments_tb;
    localparam logic [2:0] REG_ROWS     = 3'd0;
    localparam logic [2:0] REG_COLS     = 3'd1;
    localparam logic [2:0] REG_MOM_STEP = 3'd2;
    localparam logic [2:0] REG_POS_STEP = 3'd3;
    localparam logic [2:0] REG_TWO_PI   = 3'd4;
    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES = 3000;
    localparam int HOLD_AT = 300;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [95:0]   i_s_tdata = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [175:0]  o_m_tdata;
    logic [1:0]    o_m_tuser;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_data = '0;

    int errors, pending;
    int tx_idle = 23, rx_idle = 50;
    int n_sent = 0;
    int hold_left = 0;
    bit held = 0;
    int rows_eff = 256, cols_eff = 256;

    always #2 i_clk = ~i_clk;

    grid_trapezoid_moments u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    grid_trapezoid_moments_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver: random back-pressure, plus one long hold-off to fill the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (!held && n_sent >= HOLD_AT) begin
            held <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("grid_trapezoid_moments_tb NOT OK");
        $finish;
    end

    function automatic int clamp_count(input logic [12:0] v);
        if (v < 2) return 2;
        if (v > 4096) return 4096;
        return v;
    endfunction

    task automatic send_sample(input logic [31:0] smp, input logic [31:0] x,
                               input logic [31:0] k);
        while ($urandom_range(99) < tx_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {k, x, smp};
        do @(posedge i_clk); while (!o_s_tready);
        n_sent++;
    endtask

    // Drop valid, drain every result and let the block settle
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_ROWS) rows_eff = clamp_count(val[12:0]);
        if (idx == REG_COLS) cols_eff = clamp_count(val[12:0]);
    endtask

    task automatic send_grid(input int noise_pct);
        logic [31:0] x, smp, k;
        for (int r = 0; r < rows_eff; r++) begin
            x = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            for (int c = 0; c < cols_eff; c++) begin
                smp = ($urandom_range(99) < noise_pct) ? $urandom()
                                                       : $urandom_range(0, ONE_Q24);
                k = ($urandom_range(99) < noise_pct) ? $urandom()
                                                     : 32'((c - cols_eff / 2) << 15);
                send_sample(smp, ($urandom_range(99) < noise_pct) ? $urandom() : x, k);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest grid with field extremes
        write_reg(REG_ROWS, 32'd2);
        write_reg(REG_COLS, 32'd2);
        write_reg(REG_MOM_STEP, ONE_Q24);
        write_reg(REG_POS_STEP, ONE_Q24);
        write_reg(REG_TWO_PI, 32'd0);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        // Zero norm
        repeat (4) send_sample(32'h0, $urandom(), $urandom());
        // Negative variance: a negative far row partly cancels the norm
        send_sample(ONE_Q24, 32'h0, 32'h0001_0000);
        send_sample(ONE_Q24, 32'h0, 32'h0001_0000);
        send_sample(32'hFF80_0000, 32'h000A_0000, 32'h0001_0000);
        send_sample(32'hFF80_0000, 32'h000A_0000, 32'h0001_0000);
        settle();
        // Largest spacings with the 1/2pi scale, then zero momentum spacing
        write_reg(REG_MOM_STEP, 32'hFFFF_FFFF);
        write_reg(REG_POS_STEP, 32'hFFFF_FFFF);
        write_reg(REG_TWO_PI, 32'd1);
        send_grid(0);
        settle();
        write_reg(REG_MOM_STEP, 32'd0);
        write_reg(REG_POS_STEP, 32'd1);
        write_reg(REG_TWO_PI, 32'd0);
        send_grid(0);
        settle();
        // Oversized column count, then shrunk mid-row so the row closes at once
        write_reg(REG_MOM_STEP, ONE_Q24);
        write_reg(REG_POS_STEP, ONE_Q24);
        write_reg(REG_COLS, 32'h1FFF);
        repeat (3) send_sample($urandom_range(0, ONE_Q24), 32'h0002_0000, 32'h0001_0000);
        settle();
        write_reg(REG_COLS, 32'd1);
        send_sample(ONE_Q24, 32'h0002_0000, 32'h0001_0000);
        repeat (2) send_sample(ONE_Q24, 32'h0003_0000, 32'h0002_0000);
        settle();
        // Oversized row count, then shrunk mid-grid
        write_reg(REG_ROWS, 32'h1FFF);
        write_reg(REG_COLS, 32'd2);
        repeat (6) send_sample($urandom_range(0, ONE_Q24), 32'h0001_0000, 32'h0001_0000);
        settle();
        write_reg(REG_ROWS, 32'd0);
        repeat (2) send_sample(ONE_Q24, 32'hFFFF_0000, 32'h0001_0000);
        settle();

        // Random grids across three idle patterns
        write_reg(REG_ROWS, 32'd3);
        write_reg(REG_COLS, 32'd3);
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 23 : (ph == 1) ? 50 : 0;
            rx_idle = (ph == 0) ? 50 : (ph == 1) ? 23 : 0;
            while (n_sent < (ph + 1) * 250) begin
                if ($urandom_range(99) < 25) begin
                    settle();
                    write_reg(REG_ROWS, $urandom_range(2, 5));
                    write_reg(REG_COLS, $urandom_range(2, 6));
                    write_reg(REG_MOM_STEP, ($urandom_range(1) != 0) ? $urandom()
                                            : $urandom_range(32'h0040_0000, 32'h0400_0000));
                    write_reg(REG_POS_STEP, ($urandom_range(1) != 0) ? $urandom()
                                            : $urandom_range(32'h0040_0000, 32'h0400_0000));
                    write_reg(REG_TWO_PI, $urandom_range(1));
                end
                send_grid(($urandom_range(99) < 70) ? 0 : 15);
            end
        end

        // Drain and deliver the verdict
        settle();
        if (errors == 0 && pending == 0) begin
            $display("grid_trapezoid_moments_tb OK");
        end else begin
            $display("grid_trapezoid_moments_tb NOT OK");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/gtm_pkg.sv
hdl/gtm_mul.sv
hdl/gtm_dsq.sv
hdl/gtm_dp.sv
hdl/gtm_ctrl.sv
hdl/grid_trapezoid_moments.sv
tb/grid_trapezoid_moments_checker.sv
tb/grid_trapezoid_moments_tb.sv
